### hw/rtl/iirdf2_pkg.sv
// Shared types and constants for the direct-form-II IIR filter.
`timescale 1ns / 1ps

package iirdf2_pkg;

    localparam int TAPS_DEF = 16;

    localparam logic signed [31:0] UNIT_COEF = 32'sh1000_0000;
    localparam logic signed [31:0] W_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] W_MIN     = 32'sh8000_0000;
    localparam logic signed [63:0] Y_MAX     = 64'sd8388607;
    localparam logic signed [63:0] Y_MIN     = -64'sd8388608;
    localparam logic signed [63:0] Y_ROUND   = 64'sd524288;

    typedef enum logic [1:0] {
        OP_FILTER = 2'd0,
        OP_WR_B   = 2'd1,
        OP_WR_A   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC_A,
        S_DRAIN_A,
        S_DIV_GO,
        S_DIV_WAIT,
        S_MAC_B,
        S_DRAIN_B,
        S_OUT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic x_load;
        logic coef_wr_a;
        logic coef_wr_b;
        logic dly_clear;
        logic issue;
        logic sel_b;
        logic div_start;
        logic acc_clr;
        logic out_load;
        logic out_err;
        logic dly_push;
    } t_cmd;

    typedef struct packed {
        logic a0_zero;
        logic pipe_busy;
        logic div_busy;
    } t_status;

endpackage

### hw/rtl/iirdf2_in_if.sv
// Input channel: operation, coefficient write fields and sample.
`timescale 1ns / 1ps

interface iirdf2_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [3:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [23:0] sample;

    modport source (output valid, output op, output coef_index, output coef_value,
                    output sample, input ready);
    modport sink   (input valid, input op, input coef_index, input coef_value,
                    input sample, output ready);
endinterface

### hw/rtl/iirdf2_out_if.sv
// Output channel: filtered sample and status flags.
`timescale 1ns / 1ps

interface iirdf2_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] filtered_sample;
    logic               saturated;
    logic               divide_error;

    modport source (output valid, output filtered_sample, output saturated,
                    output divide_error, input ready);
    modport sink   (input valid, input filtered_sample, input saturated,
                    input divide_error, output ready);
endinterface

### hw/rtl/iirdf2_div.sv
// Radix-4 restoring divider for w = num * 2^8 / den with saturation to 32 bits.
`timescale 1ns / 1ps

module iirdf2_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_busy,
    output logic signed [31:0] o_w,
    output logic               o_clip
);

    localparam int QW    = 32;
    localparam int BPC   = 2;
    localparam int STEPS = QW / BPC;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic               r_busy;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_neg;
    logic [31:0]        r_d;
    logic [31:0]        r_rem;
    logic [31:0]        r_sh;
    logic signed [31:0] r_w;
    logic               r_clip;

    logic [63:0] w_n_abs;
    logic [31:0] w_d_abs;
    logic        w_ovf;
    logic [31:0] n_rem;
    logic [31:0] n_sh;
    logic [31:0] w_lim;

    always_comb begin
        w_n_abs = i_num[63] ? 64'(-i_num) : 64'(i_num);
        w_d_abs = i_den[31] ? 32'(-i_den) : 32'(i_den);
        // quotient would need more than 32 bits
        w_ovf   = w_n_abs >= {8'b0, w_d_abs, 24'b0};
        w_lim   = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end

    // two quotient bits per cycle; remainder stays below 2^31
    always_comb begin
        logic [31:0] t;
        logic [31:0] rem;
        logic [31:0] sh;
        rem = r_rem;
        sh  = r_sh;
        for (int i = 0; i < BPC; i++) begin
            t = {rem[30:0], sh[31]};
            if (t >= r_d) begin
                rem = t - r_d;
                sh  = {sh[30:0], 1'b1};
            end else begin
                rem = t;
                sh  = {sh[30:0], 1'b0};
            end
        end
        n_rem = rem;
        n_sh  = sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !w_ovf;
            r_cnt  <= CNT_W'(STEPS);
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[63] ^ i_den[31];
            r_d   <= w_d_abs;
            r_rem <= w_n_abs[55:24];
            r_sh  <= {w_n_abs[23:0], 8'b0};
            if (w_ovf) begin
                r_w    <= (i_num[63] ^ i_den[31]) ? iirdf2_pkg::W_MIN : iirdf2_pkg::W_MAX;
                r_clip <= 1'b1;
            end
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_rem <= n_rem;
                r_sh  <= n_sh;
            end else if (r_sh > w_lim) begin
                r_w    <= r_neg ? iirdf2_pkg::W_MIN : iirdf2_pkg::W_MAX;
                r_clip <= 1'b1;
            end else begin
                r_w    <= r_neg ? -$signed(r_sh) : $signed(r_sh);
                r_clip <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_w    = r_w;
    assign o_clip = r_clip;

endmodule

### hw/rtl/iirdf2_dp.sv
// Datapath: coefficient and delay memories, shared MAC, divider and result register.
`timescale 1ns / 1ps

module iirdf2_dp #(
    parameter int TAPS = iirdf2_pkg::TAPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  iirdf2_pkg::t_cmd          i_cmd,
    input  logic [$clog2(TAPS)-1:0]   i_k,
    input  logic [3:0]                i_coef_index,
    input  logic signed [31:0]        i_coef_value,
    input  logic signed [23:0]        i_sample,
    output iirdf2_pkg::t_status       o_status,
    output logic signed [23:0]        o_filtered_sample,
    output logic                      o_saturated,
    output logic                      o_divide_error
);

    localparam int TAP_W  = $clog2(TAPS);
    localparam int DDEPTH = 1 << TAP_W;
    localparam int IW     = (TAP_W + 1 > 5) ? TAP_W + 1 : 5;

    // coefficient and delay stores
    logic signed [31:0] r_a_mem [TAPS];
    logic signed [31:0] r_b_mem [TAPS];
    logic signed [31:0] r_d_mem [DDEPTH];
    logic [TAPS-1:0]    r_a_vld;
    logic [TAPS-1:0]    r_b_vld;
    logic [DDEPTH-1:0]  r_d_vld;
    logic [TAP_W-1:0]   r_head;
    logic signed [31:0] r_a0;
    logic signed [31:0] r_b0;

    // MAC pipeline
    logic               r_rd_v;
    logic               r_rd_w;
    logic               r_rd_selb;
    logic signed [31:0] r_a_q;
    logic signed [31:0] r_b_q;
    logic signed [31:0] r_d_q;
    logic               r_a_v;
    logic               r_b_v;
    logic               r_d_v;
    logic               r_prod_v;
    logic signed [63:0] r_prod;
    logic signed [63:0] r_acc;

    logic signed [23:0] r_filtered;
    logic               r_sat;
    logic               r_err;

    logic [IW-1:0]      w_idx;
    logic               w_idx_ok;
    logic [TAP_W-1:0]   w_waddr;
    logic [TAP_W-1:0]   w_daddr;
    logic [TAP_W-1:0]   w_push_addr;
    logic signed [31:0] w_opc;
    logic signed [31:0] w_opd;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_y_full;
    logic signed [23:0] w_y_sat;
    logic               w_y_clip;
    logic               w_div_busy;
    logic signed [31:0] w_w;
    logic               w_div_clip;

    assign w_idx       = IW'(i_coef_index);
    assign w_idx_ok    = w_idx < IW'(TAPS);
    assign w_waddr     = w_idx[TAP_W-1:0];
    assign w_daddr     = r_head + i_k - TAP_W'(1);
    assign w_push_addr = r_head - TAP_W'(1);

    // memory arrays
    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr_a && w_idx_ok) begin
            r_a_mem[w_waddr] <= i_coef_value;
        end
        if (i_cmd.coef_wr_b && w_idx_ok) begin
            r_b_mem[w_waddr] <= i_coef_value;
        end
        if (i_cmd.dly_push) begin
            r_d_mem[w_push_addr] <= w_w;
        end
        if (i_cmd.issue) begin
            r_a_q <= r_a_mem[i_k];
            r_b_q <= r_b_mem[i_k];
            r_d_q <= r_d_mem[w_daddr];
        end
    end

    // valid bits: an entry not written since reset or clear reads as its reset value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_b_vld <= '0;
            r_d_vld <= '0;
            r_head  <= '0;
            r_a0    <= iirdf2_pkg::UNIT_COEF;
            r_b0    <= iirdf2_pkg::UNIT_COEF;
        end else begin
            if (i_cmd.coef_wr_a && w_idx_ok) begin
                r_a_vld[w_waddr] <= 1'b1;
                if (w_idx == '0) begin
                    r_a0 <= i_coef_value;
                end
            end
            if (i_cmd.coef_wr_b && w_idx_ok) begin
                r_b_vld[w_waddr] <= 1'b1;
                if (w_idx == '0) begin
                    r_b0 <= i_coef_value;
                end
            end
            if (i_cmd.dly_clear) begin
                r_d_vld <= '0;
            end else if (i_cmd.dly_push) begin
                r_d_vld[w_push_addr] <= 1'b1;
                r_head               <= w_push_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.issue;
            r_prod_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_w    <= i_k == '0;
            r_rd_selb <= i_cmd.sel_b;
            r_a_v     <= r_a_vld[i_k];
            r_b_v     <= r_b_vld[i_k];
            r_d_v     <= r_d_vld[w_daddr];
        end
    end

    // tap zero of the numerator multiplies the fresh w instead of a delay word
    always_comb begin
        if (r_rd_w) begin
            w_opc = r_b0;
            w_opd = w_w;
        end else begin
            if (r_rd_selb) begin
                w_opc = r_b_v ? r_b_q : '0;
            end else begin
                w_opc = r_a_v ? r_a_q : '0;
            end
            w_opd = r_d_v ? r_d_q : '0;
        end
        w_prod = w_opc * w_opd;
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_prod <= w_prod;
        end
        if (i_cmd.x_load) begin
            r_acc <= 64'(i_sample) <<< 20;
        end else if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + (r_prod >>> 8);
        end
    end

    iirdf2_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_acc),
        .i_den   (r_a0),
        .o_busy  (w_div_busy),
        .o_w     (w_w),
        .o_clip  (w_div_clip)
    );

    // round half up to Q1.23 and clip
    always_comb begin
        w_y_full = (r_acc + iirdf2_pkg::Y_ROUND) >>> 20;
        w_y_clip = 1'b1;
        if (w_y_full > iirdf2_pkg::Y_MAX) begin
            w_y_sat = 24'(iirdf2_pkg::Y_MAX);
        end else if (w_y_full < iirdf2_pkg::Y_MIN) begin
            w_y_sat = 24'(iirdf2_pkg::Y_MIN);
        end else begin
            w_y_sat  = w_y_full[23:0];
            w_y_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_err) begin
                r_filtered <= '0;
                r_sat      <= 1'b0;
                r_err      <= 1'b1;
            end else begin
                r_filtered <= w_y_sat;
                r_sat      <= w_y_clip | w_div_clip;
                r_err      <= 1'b0;
            end
        end
    end

    assign o_status.a0_zero   = r_a0 == '0;
    assign o_status.pipe_busy = r_rd_v | r_prod_v;
    assign o_status.div_busy  = w_div_busy;

    assign o_filtered_sample = r_filtered;
    assign o_saturated       = r_sat;
    assign o_divide_error    = r_err;

endmodule

### hw/rtl/iirdf2_ctrl.sv
// Controller: sequences coefficient writes, the two MAC passes, the divide and the result.
`timescale 1ns / 1ps

module iirdf2_ctrl #(
    parameter int TAPS = iirdf2_pkg::TAPS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_op,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    input  logic [4:0]                i_nb_taps,
    input  logic [4:0]                i_na_taps,
    input  iirdf2_pkg::t_status       i_status,
    output iirdf2_pkg::t_cmd          o_cmd,
    output logic [$clog2(TAPS)-1:0]   o_k
);

    localparam int TAP_W = $clog2(TAPS);
    localparam int CW    = (TAP_W + 1 > 5) ? TAP_W + 1 : 5;

    iirdf2_pkg::t_state r_state;
    iirdf2_pkg::t_state n_state;
    logic [TAP_W-1:0]   r_k;
    logic [TAP_W-1:0]   n_k;
    logic               r_out_valid;

    logic               w_accept;
    logic               w_space;
    logic [TAP_W-1:0]   w_na_last;
    logic [TAP_W-1:0]   w_nb_last;
    iirdf2_pkg::t_op    w_op;

    // tap count clamped to 1..TAPS, returned as index of the last tap
    function automatic logic [TAP_W-1:0] last_tap(input logic [4:0] cnt);
        logic [CW-1:0] c;
        logic [CW-1:0] e;
        c = CW'(cnt);
        if (c == '0) begin
            e = CW'(1);
        end else if (c > CW'(TAPS)) begin
            e = CW'(TAPS);
        end else begin
            e = c;
        end
        return TAP_W'(e - CW'(1));
    endfunction

    assign w_na_last = last_tap(i_na_taps);
    assign w_nb_last = last_tap(i_nb_taps);
    assign w_op      = iirdf2_pkg::t_op'(i_op);
    assign w_accept  = i_in_valid && (r_state == iirdf2_pkg::S_IDLE);
    assign w_space   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            iirdf2_pkg::S_IDLE: begin
                if (w_accept && w_op == iirdf2_pkg::OP_FILTER) begin
                    if (i_status.a0_zero) begin
                        n_state = iirdf2_pkg::S_ERR;
                    end else if (w_na_last != '0) begin
                        n_state = iirdf2_pkg::S_MAC_A;
                        n_k     = TAP_W'(1);
                    end else begin
                        n_state = iirdf2_pkg::S_DIV_GO;
                    end
                end
            end
            iirdf2_pkg::S_MAC_A: begin
                if (r_k == w_na_last) begin
                    n_state = iirdf2_pkg::S_DRAIN_A;
                end else begin
                    n_k = r_k + TAP_W'(1);
                end
            end
            iirdf2_pkg::S_DRAIN_A: begin
                if (!i_status.pipe_busy) begin
                    n_state = iirdf2_pkg::S_DIV_GO;
                end
            end
            iirdf2_pkg::S_DIV_GO: begin
                n_state = iirdf2_pkg::S_DIV_WAIT;
            end
            iirdf2_pkg::S_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = iirdf2_pkg::S_MAC_B;
                    n_k     = '0;
                end
            end
            iirdf2_pkg::S_MAC_B: begin
                if (r_k == w_nb_last) begin
                    n_state = iirdf2_pkg::S_DRAIN_B;
                end else begin
                    n_k = r_k + TAP_W'(1);
                end
            end
            iirdf2_pkg::S_DRAIN_B: begin
                if (!i_status.pipe_busy) begin
                    n_state = iirdf2_pkg::S_OUT;
                end
            end
            iirdf2_pkg::S_OUT, iirdf2_pkg::S_ERR: begin
                if (w_space) begin
                    n_state = iirdf2_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iirdf2_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_in_ready      = r_state == iirdf2_pkg::S_IDLE;
        o_cmd.x_load    = w_accept && w_op == iirdf2_pkg::OP_FILTER;
        o_cmd.coef_wr_b = w_accept && w_op == iirdf2_pkg::OP_WR_B;
        o_cmd.coef_wr_a = w_accept && w_op == iirdf2_pkg::OP_WR_A;
        o_cmd.dly_clear = w_accept && w_op == iirdf2_pkg::OP_CLEAR;
        unique case (r_state)
            iirdf2_pkg::S_MAC_A: begin
                o_cmd.issue = 1'b1;
            end
            iirdf2_pkg::S_MAC_B: begin
                o_cmd.issue = 1'b1;
                o_cmd.sel_b = 1'b1;
            end
            iirdf2_pkg::S_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.acc_clr   = 1'b1;
            end
            iirdf2_pkg::S_OUT: begin
                o_cmd.out_load = w_space;
                o_cmd.dly_push = w_space;
            end
            iirdf2_pkg::S_ERR: begin
                o_cmd.out_load = w_space;
                o_cmd.out_err  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iirdf2_pkg::S_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_k         = r_k;

endmodule

### hw/rtl/iir_filter_direct_form2.sv
// Direct-form-II IIR filter: w = (x + sum a[k]d[k-1]) / a0, y = sum b[k]d[k-1] + b0*w.
// Sample latency, accept to result valid, is set by one shared 32x32 MAC and a radix-4
// divider; the a pass is skipped when na is 1, and an overflowing divide is not busy.
// One sample in flight; the next item is taken the cycle after the result is registered.
// Coefficient writes and delay clears finish on acceptance; a zero a0 gives an error result.
// Synchronous active-low reset: tap counts 1, a0 = b0 = 1.0, other taps and delay line 0.
`timescale 1ns / 1ps

module iir_filter_direct_form2 #(
    parameter int TAPS = iirdf2_pkg::TAPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    iirdf2_in_if.sink           i_in,
    iirdf2_out_if.source        o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic REG_NUM_B_TAPS = 1'b0;
    localparam logic REG_NUM_A_TAPS = 1'b1;

    logic [4:0]                 r_nb_taps;
    logic [4:0]                 r_na_taps;
    iirdf2_pkg::t_cmd           w_cmd;
    iirdf2_pkg::t_status        w_status;
    logic [$clog2(TAPS)-1:0]    w_k;
    logic                       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb_taps <= 5'd1;
            r_na_taps <= 5'd1;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_NUM_A_TAPS) begin
                r_na_taps <= pwdata[4:0];
            end else begin
                r_nb_taps <= pwdata[4:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_NUM_B_TAPS) ? 32'(r_nb_taps) : 32'(r_na_taps);

    iirdf2_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_op        (i_in.op),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_nb_taps   (r_nb_taps),
        .i_na_taps   (r_na_taps),
        .i_status    (w_status),
        .o_cmd       (w_cmd),
        .o_k         (w_k)
    );

    iirdf2_dp #(
        .TAPS (TAPS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_k               (w_k),
        .i_coef_index      (i_in.coef_index),
        .i_coef_value      (i_in.coef_value),
        .i_sample          (i_in.sample),
        .o_status          (w_status),
        .o_filtered_sample (o_out.filtered_sample),
        .o_saturated       (o_out.saturated),
        .o_divide_error    (o_out.divide_error)
    );

    // MAC never runs while the divider still owns w
    a_issue_not_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> !w_status.div_busy)
        else $error("MAC issue while divider busy");

    // a new transfer is only taken with the datapath drained
    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (!w_status.pipe_busy && !w_status.div_busy))
        else $error("input ready with datapath busy");

    a_sample_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.op == iirdf2_pkg::OP_FILTER) |=> !i_in.ready)
        else $error("input ready right after a sample transfer");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.divide_error) |->
            (o_out.filtered_sample == '0 && !o_out.saturated))
        else $error("divide error result not zeroed");

endmodule
